[src/gcb_pkg.sv]
package gcb_pkg;

  // number of cordic iterations, bounded by the arctangent table
  localparam int CORDIC_STAGES = 24;
  localparam int ATAN_LEN      = 40;
  localparam int NSTG          = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;

  // rotation datapath width (angles and sin/cos in q30) and vectoring width
  localparam int AW = 34;
  localparam int VW = 36;

  typedef logic signed [AW-1:0] ang_t;
  typedef logic signed [VW-1:0] vec_t;
  typedef logic signed [31:0]   q30_t;

  // sideband that travels with a beat through the pipeline
  typedef struct packed {
    logic vld;
    logic zero;
  } meta_t;

  localparam ang_t PI_Q30       = 34'sd3373259426;
  localparam ang_t HALF_PI_Q30  = 34'sd1686629713;
  localparam ang_t TWO_PI_Q30   = 34'sd6746518852;
  localparam ang_t INV_GAIN_Q30 = 34'sd652032874;

  // 180/pi in q24
  localparam logic [29:0] RAD2DEG_Q24 = 30'd961263669;
  // 360 degrees in q16
  localparam logic [24:0] FULL_TURN_Q16 = 25'd23592960;

  // atan(2^-i) in q30, truncated
  function automatic ang_t atan_q30(input int i);
    ang_t r;
    case (i)
      0:  r = 34'sd843314856;
      1:  r = 34'sd497837829;
      2:  r = 34'sd263043836;
      3:  r = 34'sd133525158;
      4:  r = 34'sd67021686;
      5:  r = 34'sd33543515;
      6:  r = 34'sd16775850;
      7:  r = 34'sd8388437;
      8:  r = 34'sd4194282;
      9:  r = 34'sd2097149;
      10: r = 34'sd1048575;
      11: r = 34'sd524287;
      12: r = 34'sd262143;
      13: r = 34'sd131071;
      14: r = 34'sd65535;
      15: r = 34'sd32767;
      16: r = 34'sd16383;
      17: r = 34'sd8191;
      18: r = 34'sd4095;
      19: r = 34'sd2047;
      20: r = 34'sd1023;
      21: r = 34'sd511;
      22: r = 34'sd255;
      23: r = 34'sd127;
      24: r = 34'sd63;
      25: r = 34'sd31;
      26: r = 34'sd15;
      27: r = 34'sd7;
      28: r = 34'sd3;
      29: r = 34'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

[src/great_circle_bearing.sv]
// throughput: one beat per cycle while the skid entry is free; every stage is a register, the cordic rotation
// and vectoring chains are unrolled one iteration per stage
// a one-entry skid buffer behind the output register lets the pipe run while a result waits
// reset: synchronous active-low rst_n clears all valid bits and the skid buffer
module great_circle_bearing (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [29:0] in_start_latitude,
  input  logic signed [30:0] in_start_longitude,
  input  logic signed [29:0] in_end_latitude,
  input  logic signed [30:0] in_end_longitude,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [24:0]        out_bearing_degrees
);
  import gcb_pkg::*;

  logic en;
  ang_t [2:0] ang;
  ang_t lon1_q30, lon2_q30;
  logic sc_vld;
  q30_t [2:0] sn, cs;
  logic out_vld_r, skid_vld_r;

  // pipeline advances whenever the skid entry is free
  assign en = !skid_vld_r;
  assign in_stall = skid_vld_r;

  // q2.28 latitude and q3.28 longitude to q30, longitude difference
  assign lon1_q30 = {in_start_longitude[30], in_start_longitude, 2'b00};
  assign lon2_q30 = {in_end_longitude[30], in_end_longitude, 2'b00};
  assign ang[0] = {{2{in_start_latitude[29]}}, in_start_latitude, 2'b00};
  assign ang[1] = {{2{in_end_latitude[29]}}, in_end_latitude, 2'b00};
  assign ang[2] = lon2_q30 - lon1_q30;

  gcb_sincos u_sincos (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (in_valid),
    .ang_i   (ang),
    .out_vld (sc_vld),
    .sin_o   (sn),
    .cos_o   (cs)
  );

  // products: c2*sd, c1*s2, s1*c2
  logic signed [63:0] pa1_r, pb1_r, pc1_r;
  q30_t cd1_r;
  logic vld1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else if (en) begin
      vld1_r <= sc_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa1_r <= 64'(cs[1]) * 64'(sn[2]);
      pb1_r <= 64'(cs[0]) * 64'(sn[1]);
      pc1_r <= 64'(sn[0]) * 64'(cs[1]);
      cd1_r <= cs[2];
    end
  end

  // back to q30
  logic signed [32:0] x2_r, y2_r;
  q30_t t2_r, cd2_r;
  logic vld2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r <= 1'b0;
    end else if (en) begin
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x2_r  <= pa1_r[62:30];
      y2_r  <= pb1_r[62:30];
      t2_r  <= pc1_r[61:30];
      cd2_r <= cd1_r;
    end
  end

  // three-factor term
  logic signed [63:0] pd3_r;
  logic signed [32:0] x3_r, y3_r;
  logic vld3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld3_r <= 1'b0;
    end else if (en) begin
      vld3_r <= vld2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pd3_r <= 64'(t2_r) * 64'(cd2_r);
      x3_r  <= x2_r;
      y3_r  <= y2_r;
    end
  end

  // y component and the all-zero flag
  logic signed [33:0] y4_nxt;
  logic signed [33:0] y4_r;
  logic signed [32:0] x4_r;
  meta_t meta4_r;

  assign y4_nxt = 34'(y3_r) - 34'($signed(pd3_r[62:30]));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meta4_r.vld <= 1'b0;
    end else if (en) begin
      meta4_r.vld <= vld3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y4_r         <= y4_nxt;
      x4_r         <= x3_r;
      meta4_r.zero <= (x3_r == '0) && (y4_nxt == '0);
    end
  end

  meta_t meta_v;
  ang_t z_v;

  gcb_vector u_vector (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .meta_i (meta4_r),
    .u_i    (36'(y4_r)),
    .v_i    (36'(x4_r)),
    .meta_o (meta_v),
    .z_o    (z_v)
  );

  // radians to degrees, split into two partial products
  logic signed [48:0] ph1_r;
  logic [45:0] pl1_r;
  meta_t meta_d1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meta_d1_r.vld <= 1'b0;
    end else if (en) begin
      meta_d1_r <= meta_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ph1_r <= 49'($signed(z_v[AW-1:16])) * 49'($signed({1'b0, RAD2DEG_Q24}));
      pl1_r <= 46'(z_v[15:0]) * 46'(RAD2DEG_Q24);
    end
  end

  // sum, round half up, scale to q16
  logic signed [65:0] sum2;
  logic signed [27:0] deg2_r;
  meta_t meta_d2_r;

  assign sum2 = (66'(ph1_r) <<< 16) + $signed(66'(pl1_r)) + (66'sd1 <<< 37);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meta_d2_r.vld <= 1'b0;
    end else if (en) begin
      meta_d2_r <= meta_d1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      deg2_r <= sum2[65:38];
    end
  end

  // fold into [0, 360)
  localparam logic signed [27:0] FULL28 = 28'($signed({1'b0, FULL_TURN_Q16}));
  logic signed [27:0] deg3;
  logic [24:0] res3_r;
  logic vld_f_r;

  always_comb begin
    deg3 = deg2_r;
    if (deg3 < 0) begin
      deg3 = deg3 + FULL28;
    end
    if (deg3 >= FULL28) begin
      deg3 = deg3 - FULL28;
    end
    if (deg3 < 0) begin
      deg3 = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_f_r <= 1'b0;
    end else if (en) begin
      vld_f_r <= meta_d2_r.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res3_r <= meta_d2_r.zero ? '0 : deg3[24:0];
    end
  end

  // output register with one skid entry
  logic [24:0] out_data_r, skid_data_r;
  logic out_fire, take;

  assign out_fire = out_vld_r && !out_stall;
  assign take     = vld_f_r && en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (out_fire) begin
        skid_vld_r <= 1'b0;
      end
    end else if (take) begin
      if (out_vld_r && !out_fire) begin
        skid_vld_r <= 1'b1;
      end else begin
        out_vld_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (out_fire) begin
        out_data_r <= skid_data_r;
      end
    end else if (take) begin
      if (out_vld_r && !out_fire) begin
        skid_data_r <= res3_r;
      end else begin
        out_data_r <= res3_r;
      end
    end
  end

  assign out_valid           = out_vld_r;
  assign out_bearing_degrees = out_data_r;

  // skid entry is only ever used behind a full output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid entry full while output register empty");

  // bearing always below a full turn
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_data_r < FULL_TURN_Q16))
    else $error("bearing out of range");

  // a blocked output keeps the input side stalled
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_vld_r && out_stall) |=> skid_vld_r)
    else $error("skid entry dropped while output stalled");

  // reset empties the output side
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> (!out_vld_r && !skid_vld_r))
    else $error("output side not cleared by reset");

endmodule

[src/gcb_sincos.sv]
module gcb_sincos (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_vld,
  input  gcb_pkg::ang_t [2:0]     ang_i,
  output logic                    out_vld,
  output gcb_pkg::q30_t [2:0]     sin_o,
  output gcb_pkg::q30_t [2:0]     cos_o
);
  import gcb_pkg::*;

  ang_t x_r    [NSTG+1][3];
  ang_t y_r    [NSTG+1][3];
  ang_t z_r    [NSTG+1][3];
  logic flip_r [NSTG+1][3];
  logic vld_r  [NSTG+1];

  ang_t red_a  [3];
  logic red_f  [3];
  q30_t sin_r  [3];
  q30_t cos_r  [3];
  logic ovld_r;

  // range reduction into [-pi/2, pi/2] with a sign flip
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      red_a[l] = ang_i[l];
      red_f[l] = 1'b0;
      if (red_a[l] > PI_Q30) begin
        red_a[l] = red_a[l] - TWO_PI_Q30;
      end else if (red_a[l] < -PI_Q30) begin
        red_a[l] = red_a[l] + TWO_PI_Q30;
      end
      if (red_a[l] > HALF_PI_Q30) begin
        red_a[l] = red_a[l] - PI_Q30;
        red_f[l] = 1'b1;
      end else if (red_a[l] < -HALF_PI_Q30) begin
        red_a[l] = red_a[l] + PI_Q30;
        red_f[l] = 1'b1;
      end
    end
  end

  // reduction stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        x_r[0][l]    <= INV_GAIN_Q30;
        y_r[0][l]    <= '0;
        z_r[0][l]    <= red_a[l];
        flip_r[0][l] <= red_f[l];
      end
    end
  end

  // rotation stages
  for (genvar i = 0; i < NSTG; i++) begin : g_stg
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else if (en) begin
        vld_r[i+1] <= vld_r[i];
      end
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
      ang_t xs, ys;
      assign xs = x_r[i][l] >>> i;
      assign ys = y_r[i][l] >>> i;

      always_ff @(posedge clk) begin
        if (en) begin
          if (!z_r[i][l][AW-1]) begin
            x_r[i+1][l] <= x_r[i][l] - ys;
            y_r[i+1][l] <= y_r[i][l] + xs;
            z_r[i+1][l] <= z_r[i][l] - atan_q30(i);
          end else begin
            x_r[i+1][l] <= x_r[i][l] + ys;
            y_r[i+1][l] <= y_r[i][l] - xs;
            z_r[i+1][l] <= z_r[i][l] + atan_q30(i);
          end
          flip_r[i+1][l] <= flip_r[i][l];
        end
      end
    end
  end

  // undo the half-turn shift
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovld_r <= 1'b0;
    end else if (en) begin
      ovld_r <= vld_r[NSTG];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        sin_r[l] <= flip_r[NSTG][l] ? 32'(-y_r[NSTG][l]) : 32'(y_r[NSTG][l]);
        cos_r[l] <= flip_r[NSTG][l] ? 32'(-x_r[NSTG][l]) : 32'(x_r[NSTG][l]);
      end
    end
  end

  assign out_vld = ovld_r;
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      sin_o[l] = sin_r[l];
      cos_o[l] = cos_r[l];
    end
  end

endmodule

[src/gcb_vector.sv]
module gcb_vector (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  gcb_pkg::meta_t meta_i,
  input  gcb_pkg::vec_t  u_i,
  input  gcb_pkg::vec_t  v_i,
  output gcb_pkg::meta_t meta_o,
  output gcb_pkg::ang_t  z_o
);
  import gcb_pkg::*;

  vec_t  u_r    [NSTG+1];
  vec_t  v_r    [NSTG+1];
  ang_t  z_r    [NSTG+1];
  meta_t meta_r [NSTG+1];

  vec_t pu, pv;
  ang_t pz;

  // quarter-turn pre-rotation into the right half plane
  always_comb begin
    pu = u_i;
    pv = v_i;
    pz = '0;
    if (u_i[VW-1]) begin
      if (!v_i[VW-1]) begin
        pu = v_i;
        pv = -u_i;
        pz = HALF_PI_Q30;
      end else begin
        pu = -v_i;
        pv = u_i;
        pz = -HALF_PI_Q30;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meta_r[0].vld <= 1'b0;
    end else if (en) begin
      meta_r[0] <= meta_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u_r[0] <= pu;
      v_r[0] <= pv;
      z_r[0] <= pz;
    end
  end

  // vectoring stages, drive v toward zero
  for (genvar i = 0; i < NSTG; i++) begin : g_stg
    vec_t us, vs;
    assign us = u_r[i] >>> i;
    assign vs = v_r[i] >>> i;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        meta_r[i+1].vld <= 1'b0;
      end else if (en) begin
        meta_r[i+1] <= meta_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (!v_r[i][VW-1]) begin
          u_r[i+1] <= u_r[i] + vs;
          v_r[i+1] <= v_r[i] - us;
          z_r[i+1] <= z_r[i] + atan_q30(i);
        end else begin
          u_r[i+1] <= u_r[i] - vs;
          v_r[i+1] <= v_r[i] + us;
          z_r[i+1] <= z_r[i] - atan_q30(i);
        end
      end
    end
  end

  assign meta_o = meta_r[NSTG];
  assign z_o    = z_r[NSTG];

endmodule

[tb/gcb_checker.sv]
`timescale 1ns / 100ps

module gcb_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [29:0] in_start_latitude,
  input  logic signed [30:0] in_start_longitude,
  input  logic signed [29:0] in_end_latitude,
  input  logic signed [30:0] in_end_longitude,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [24:0]        out_bearing_degrees,
  output int                 fail_count,
  output int                 pending_count
);
  import gcb_pkg::*;

  localparam longint PI_L      = 64'sd3373259426;
  localparam longint HALF_PI_L = 64'sd1686629713;
  localparam longint TWO_PI_L  = 64'sd6746518852;
  localparam longint INV_K_L   = 64'sd652032874;
  localparam longint DEG_Q24_L = 64'sd961263669;
  localparam longint TURN_L    = 64'sd23592960;

  logic [24:0] bearing_q[$];

  // arctangent of 2^-i in q30, truncated
  function automatic longint arc_step(int i);
    return longint'(atan_q30(i));
  endfunction

  // rotation mode: sine and cosine of a q30 angle
  function automatic void rotate(input longint a, output longint s, output longint c);
    longint x, y, z, nx;
    bit flip;
    x = INV_K_L; y = 0; flip = 0;
    while (a > PI_L) a -= TWO_PI_L;
    while (a < -PI_L) a += TWO_PI_L;
    if (a > HALF_PI_L) begin
      a -= PI_L; flip = 1;
    end else if (a < -HALF_PI_L) begin
      a += PI_L; flip = 1;
    end
    z = a;
    for (int i = 0; i < NSTG; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); y = y + (x >>> i); z -= arc_step(i);
      end else begin
        nx = x + (y >>> i); y = y - (x >>> i); z += arc_step(i);
      end
      x = nx;
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endfunction

  // vectoring mode: angle of (u, v) in q30
  function automatic longint heading(longint u, longint v);
    longint z, nu, t;
    z = 0;
    if (u < 0) begin
      if (v >= 0) begin
        t = u; u = v; v = -t; z = HALF_PI_L;
      end else begin
        t = u; u = -v; v = t; z = -HALF_PI_L;
      end
    end
    for (int i = 0; i < NSTG; i++) begin
      if (v >= 0) begin
        nu = u + (v >>> i); v = v - (u >>> i); z += arc_step(i);
      end else begin
        nu = u - (v >>> i); v = v + (u >>> i); z -= arc_step(i);
      end
      u = nu;
    end
    return z;
  endfunction

  function automatic logic [24:0] bearing_of(longint la1, longint lo1, longint la2,
                                             longint lo2);
    longint s1, c1, s2, c2, sd, cd, x, y, t, deg;
    rotate(la1 * 4, s1, c1);
    rotate(la2 * 4, s2, c2);
    rotate(lo2 * 4 - lo1 * 4, sd, cd);
    x = (c2 * sd) >>> 30;
    t = (s1 * c2) >>> 30;
    y = ((c1 * s2) >>> 30) - ((t * cd) >>> 30);
    if (x == 0 && y == 0) return '0;
    deg = (heading(y, x) * DEG_Q24_L + (64'sd1 <<< 37)) >>> 38;
    if (deg < 0) deg += TURN_L;
    if (deg >= TURN_L) deg -= TURN_L;
    if (deg < 0) deg = 0;
    return deg[24:0];
  endfunction

  assign pending_count = bearing_q.size();

  // predict on input beats, compare on output beats
  always @(posedge clk) begin
    logic [24:0] want;
    if (!rst_n) begin
      fail_count <= 0;
    end else begin
      if (in_valid && !in_stall)
        bearing_q.push_back(bearing_of(in_start_latitude, in_start_longitude,
                                       in_end_latitude, in_end_longitude));
      if (out_valid && !out_stall) begin
        if (bearing_q.size() == 0) begin
          $display("%0t: unexpected bearing beat, actual %0d", $time, out_bearing_degrees);
          fail_count <= fail_count + 1;
        end else begin
          want = bearing_q.pop_front();
          if (want !== out_bearing_degrees) begin
            $display("%0t: bearing mismatch, expected %0d actual %0d", $time, want,
                     out_bearing_degrees);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

[tb/tb_great_circle_bearing.sv]
`timescale 1ns / 100ps

module tb_great_circle_bearing;
  localparam int LAT_MAX = 421657428;
  localparam int LON_MAX = 843314857;

  logic               clk = 0;
  logic               rst_n = 0;
  logic               in_valid = 0;
  logic               in_stall;
  logic signed [29:0] in_start_latitude = '0;
  logic signed [30:0] in_start_longitude = '0;
  logic signed [29:0] in_end_latitude = '0;
  logic signed [30:0] in_end_longitude = '0;
  logic               out_valid;
  logic               out_stall = 0;
  logic [24:0]        out_bearing_degrees;
  int                 fail_count, pending_count;
  bit                 hold_off = 0;

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  great_circle_bearing dut (.*);

  gcb_checker chk (.*);

  // receiver stall pattern, with one long hold-off
  always @(posedge clk) begin
    int phase;
    phase = int'(($time / 400) % 4);
    if (hold_off) out_stall <= 1;
    else if (phase == 0) out_stall <= 0;
    else out_stall <= ($urandom_range(0, 99) < phase * 15);
  end

  task automatic send(int la1, int lo1, int la2, int lo2);
    in_valid <= 1;
    in_start_latitude <= 30'(la1); in_start_longitude <= 31'(lo1);
    in_end_latitude <= 30'(la2); in_end_longitude <= 31'(lo2);
    do @(posedge clk); while (in_stall);
  endtask

  task automatic pause();
    in_valid <= 0;
    repeat ($urandom_range(1, 6)) @(posedge clk);
  endtask

  function automatic int rnd(int lim);
    return int'($urandom_range(0, 2 * lim)) - lim;
  endfunction

  initial begin
    int burst, wait_cnt;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed beats: extremes, coincident points, poles, antimeridian, raw patterns
    send(0, 0, 0, 0);
    send(LAT_MAX, 0, LAT_MAX, 0);
    send(-LAT_MAX, LON_MAX, -LAT_MAX, -LON_MAX);
    send(0, 0, LAT_MAX, 0);
    send(0, 0, -LAT_MAX, 0);
    send(0, 0, 0, 1000000);
    send(0, 1000000, 0, 0);
    send(0, -LON_MAX, 0, LON_MAX);
    send(LAT_MAX, 0, 0, 12345);
    send(-LAT_MAX, 0, 0, 12345);
    send(100, 0, 100, 1);
    send(0, 0, -1, 0);
    send(0, 0, 1, -1);
    send(32'h1fffffff, 32'h3fffffff, 32'h20000000, 32'h40000000);
    send(32'h20000000, 32'h40000000, 32'h1fffffff, 32'h3fffffff);
    send(-1, -1, -1, -1);
    send(LAT_MAX, LON_MAX, -LAT_MAX, -LON_MAX);
    pause();
    // long receiver hold-off while the sender keeps offering
    hold_off = 1;
    fork
      repeat (100) send(rnd(LAT_MAX), rnd(LON_MAX), rnd(LAT_MAX), rnd(LON_MAX));
      begin
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
    join
    // random bursts; a few beats use raw out-of-range patterns
    wait_cnt = 0;
    while (wait_cnt < 800) begin
      burst = $urandom_range(1, 30);
      repeat (burst) begin
        if ($urandom_range(0, 19) == 0)
          send($urandom, $urandom, $urandom, $urandom);
        else
          send(rnd(LAT_MAX), rnd(LON_MAX), rnd(LAT_MAX), rnd(LON_MAX));
      end
      wait_cnt += burst;
      if ($urandom_range(0, 2) != 0) pause();
    end
    in_valid <= 0;
    while (pending_count != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #400000;
    $display("*** FAILED ***");
    $finish;
  end
endmodule
